// File: hdl/msep_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and register indexes of the smooth escape-time pixel block
package msep_pkg;

    localparam int COORD_W  = 12;
    localparam int STEP_W   = 10;
    localparam int CIDX_W   = 12;
    localparam int PAL_W    = 13;
    localparam int CFG_IDX_W = 3;
    localparam int LOGF     = 24;
    localparam int ESC_LIMIT = 10000;
    localparam int LOG_OFFSET = 10;
    localparam int SQRT_W   = 52;
    localparam int SQRT_PRE = 16;   // 256 * 256 scale before the root
    localparam int SQRT_POST = 12;  // half of the log fraction width
    localparam int PAL_MAX  = 4096;

    localparam int FRAC_BITS_DEF = 40;
    localparam int ITER_CAP_DEF  = 1023;

    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_REAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_IMAG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE     = 3'd4;

    // pixel with its point c, passed from front to back
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [63:0]        cr;
        logic [63:0]        ci;
    } t_pix;

    // finished result word
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               escaped;
        logic [STEP_W-1:0]  estep;
        logic [CIDX_W-1:0]  cidx;
    } t_res;

endpackage

// File: hdl/msep_fifo.sv
`timescale 1ns / 1ps
// small first-word-fall-through queue
module msep_fifo
    import msep_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wr] <= i_data;
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: hdl/msep_front.sv
`timescale 1ns / 1ps
// front end: takes a pixel and forms its point c in the complex plane
module msep_front
    import msep_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [COORD_W-1:0] i_column,
    input  logic [COORD_W-1:0] i_row_index,
    input  logic [63:0]        i_corner_real,
    input  logic [63:0]        i_corner_imag,
    input  logic [62:0]        i_pixel_step,
    output logic               o_valid,
    output t_pix               o_pix,
    input  logic               i_qfull
);
    typedef enum logic [2:0] {
        F_IDLE,
        F_MRE,
        F_MIM,
        F_CIM,
        F_SEND
    } t_fstate;

    t_fstate            r_state;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic [74:0]        r_off;
    logic [63:0]        r_cr;
    logic [63:0]        r_ci;

    // ((2v + 1) * step) >> 1, split in two narrow products
    function automatic logic [74:0] half_off(input logic [COORD_W-1:0] v,
                                             input logic [62:0] step);
        logic [COORD_W:0] odd;
        logic [44:0]      lo;
        logic [43:0]      hi;
        logic [75:0]      prod;
        odd  = {v, 1'b1};
        lo   = odd * step[31:0];
        hi   = odd * step[62:32];
        prod = {hi, 32'd0} + 76'(lo);
        return prod[75:1];
    endfunction

    // corner plus or minus the offset, clipped to the signed 64-bit range
    function automatic logic [63:0] sat_off(input logic [63:0] corner,
                                            input logic [74:0] off,
                                            input logic sub);
        logic [63:0] b;
        logic [63:0] o;
        logic [64:0] t;
        logic [63:0] r;
        b = corner ^ {1'b1, 63'd0};
        o = (off[74:64] != '0) ? '1 : off[63:0];
        if (sub) begin
            t = {1'b0, b} - {1'b0, o};
            r = t[64] ? '0 : t[63:0];
        end else begin
            t = {1'b0, b} + {1'b0, o};
            r = t[64] ? '1 : t[63:0];
        end
        return r ^ {1'b1, 63'd0};
    endfunction

    assign o_full  = (r_state != F_IDLE);
    assign o_valid = (r_state == F_SEND);
    assign o_pix   = '{col: r_col, row: r_row, cr: r_cr, ci: r_ci};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_col   <= i_column;
                        r_row   <= i_row_index;
                        r_state <= F_MRE;
                    end
                end
                F_MRE: begin
                    r_off   <= half_off(r_col, i_pixel_step);
                    r_state <= F_MIM;
                end
                F_MIM: begin
                    r_cr    <= sat_off(i_corner_real, r_off, 1'b0);
                    r_off   <= half_off(r_row, i_pixel_step);
                    r_state <= F_CIM;
                end
                F_CIM: begin
                    r_ci    <= sat_off(i_corner_imag, r_off, 1'b1);
                    r_state <= F_SEND;
                end
                F_SEND: begin
                    if (!i_qfull) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/msep_color.sv
`timescale 1ns / 1ps
// smooth color index: two log2 passes, square root and palette modulo
module msep_color
    import msep_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [127:0]      i_mag,
    input  logic [STEP_W-1:0] i_step,
    input  logic [PAL_W-1:0]  i_pal,
    output logic              o_done,
    output logic [CIDX_W-1:0] o_index
);
    localparam logic [30:0] BIAS = 31'(2 * FRAC_BITS) << LOGF;
    localparam logic [30:0] SOFF = 31'(LOGF) << LOGF;
    localparam int QW = SQRT_W / 2 - SQRT_POST;
    localparam int MJ_W = $clog2(QW);

    typedef enum logic [2:0] {
        C_IDLE,
        C_NORM,
        C_SQ,
        C_LOG,
        C_SQRT,
        C_MOD,
        C_DONE
    } t_cstate;

    t_cstate            r_state;
    logic [127:0]       r_x;
    logic [6:0]         r_n;
    logic [31:0]        r_m;
    logic [LOGF-1:0]    r_frac;
    logic [4:0]         r_j;
    logic               r_pass;
    logic [STEP_W-1:0]  r_step;
    logic [PAL_W-1:0]   r_pal;
    logic [SQRT_W-1:0]  r_rem;
    logic [SQRT_W-1:0]  r_res;
    logic [SQRT_W-1:0]  r_bit;
    logic [QW-1:0]      r_q;
    logic [MJ_W-1:0]    r_mj;
    logic [PAL_W-1:0]   r_mr;

    logic [63:0]        w_sq;
    logic [32:0]        w_sqs;
    logic [30:0]        w_lg;
    logic [30:0]        w_l;
    logic [30:0]        w_s;
    logic [34:0]        w_base;
    logic [34:0]        w_a;
    logic [SQRT_W-1:0]  w_t;
    logic               w_ge;
    logic [SQRT_W-1:0]  w_res_n;
    logic [PAL_W-1:0]   w_mr;

    always_comb begin
        w_sq    = r_m * r_m;
        w_sqs   = w_sq[63:31];
        w_lg    = {r_n, r_frac};
        w_l     = (w_lg > BIAS) ? w_lg - BIAS : '0;
        w_s     = (w_lg > SOFF) ? w_lg - SOFF : '0;
        w_base  = {11'({1'b0, r_step} + 11'(LOG_OFFSET)), LOGF'(0)};
        w_a     = (w_base > 35'(w_s)) ? w_base - 35'(w_s) : '0;
        w_t     = r_res + r_bit;
        w_ge    = (r_rem >= w_t);
        w_res_n = w_ge ? (r_res >> 1) + r_bit : (r_res >> 1);
        w_mr    = {r_mr[PAL_W-2:0], r_q[r_mj]};
    end

    assign o_done  = (r_state == C_DONE);
    assign o_index = r_mr[CIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_mag;
                        r_n     <= 7'd127;
                        r_frac  <= '0;
                        r_pass  <= 1'b0;
                        r_step  <= i_step;
                        r_pal   <= i_pal;
                        r_state <= C_NORM;
                    end
                end
                C_NORM: begin
                    // normalize so the top set bit lands in bit 127
                    if (r_x == '0) begin
                        r_n     <= '0;
                        r_state <= C_LOG;
                    end else if (r_x[127]) begin
                        r_m     <= r_x[127:96];
                        r_j     <= '0;
                        r_state <= C_SQ;
                    end else if (r_x[127:120] == '0) begin
                        r_x <= r_x << 8;
                        r_n <= r_n - 7'd8;
                    end else begin
                        r_x <= r_x << 1;
                        r_n <= r_n - 7'd1;
                    end
                end
                C_SQ: begin
                    // one fraction bit per squaring of the mantissa
                    if (w_sqs[32]) begin
                        r_m    <= w_sqs[32:1];
                        r_frac <= {r_frac[LOGF-2:0], 1'b1};
                    end else begin
                        r_m    <= w_sqs[31:0];
                        r_frac <= {r_frac[LOGF-2:0], 1'b0};
                    end
                    r_j <= r_j + 5'd1;
                    if (r_j == 5'(LOGF - 1)) begin
                        r_state <= C_LOG;
                    end
                end
                C_LOG: begin
                    if (!r_pass) begin
                        r_x     <= 128'(w_l >> 1);
                        r_n     <= 7'd127;
                        r_frac  <= '0;
                        r_pass  <= 1'b1;
                        r_state <= C_NORM;
                    end else begin
                        r_rem   <= SQRT_W'({w_a, SQRT_PRE'(0)});
                        r_res   <= '0;
                        r_bit   <= SQRT_W'(1) << (SQRT_W - 2);
                        r_state <= C_SQRT;
                    end
                end
                C_SQRT: begin
                    if (w_ge) begin
                        r_rem <= r_rem - w_t;
                    end
                    r_res <= w_res_n;
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_q     <= QW'(w_res_n >> SQRT_POST);
                        r_mr    <= '0;
                        r_mj    <= MJ_W'(QW - 1);
                        r_state <= C_MOD;
                    end
                end
                C_MOD: begin
                    // restoring remainder, one index bit per cycle
                    r_mr <= (w_mr >= r_pal) ? w_mr - r_pal : w_mr;
                    r_mj <= r_mj - 1'b1;
                    if (r_mj == '0) begin
                        r_state <= C_DONE;
                    end
                end
                C_DONE: r_state <= C_IDLE;
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/msep_iter.sv
`timescale 1ns / 1ps
// back end: z = z^2 + c iteration on a shared 32x32 multiplier, escape test
module msep_iter
    import msep_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ITER_CAP  = ITER_CAP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_qempty,
    output logic              o_qpop,
    input  t_pix              i_pix,
    input  logic [STEP_W-1:0] i_max_iterations,
    input  logic [PAL_W-1:0]  i_pal,
    output logic              o_rvalid,
    output t_res              o_res,
    input  logic              i_rfull
);
    localparam logic [127:0] THR = 128'(ESC_LIMIT) << (2 * FRAC_BITS);
    localparam logic [3:0]   PP_LAST = 4'd12;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHK,
        B_UPD1,
        B_UPD2,
        B_ABS,
        B_MUL,
        B_COLOR,
        B_OUT
    } t_bstate;

    t_bstate            r_state;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic [63:0]        r_cr;
    logic [63:0]        r_ci;
    logic [63:0]        r_zr;
    logic [63:0]        r_zi;
    logic [63:0]        r_ar;
    logic [63:0]        r_ai;
    logic               r_sr;
    logic               r_si;
    logic [127:0]       r_acc_rr;
    logic [127:0]       r_acc_ii;
    logic [127:0]       r_acc_ri;
    logic [127:0]       r_re;
    logic [127:0]       r_im;
    logic [STEP_W-1:0]  r_k;
    logic [3:0]         r_cnt;
    logic [63:0]        r_pp;
    logic               r_pp_v;
    logic [1:0]         r_pp_sel;
    logic [1:0]         r_pp_sh;
    logic               r_escaped;
    logic [STEP_W-1:0]  r_estep;
    logic [CIDX_W-1:0]  r_cidx;

    logic [STEP_W-1:0]  w_limit;
    logic [127:0]       w_mag;
    logic               w_esc;
    logic [63:0]        w_a;
    logic [63:0]        w_b;
    logic [31:0]        w_ah;
    logic [31:0]        w_bh;
    logic [127:0]       w_ppx;
    logic signed [128:0] w_re_x;
    logic signed [128:0] w_im_x;
    logic               w_cdone;
    logic [CIDX_W-1:0]  w_cidx;

    function automatic logic [63:0] sat64(input logic [128:0] s);
        logic fits;
        fits = (&s[128:63]) || !(|s[128:63]);
        if (fits) begin
            return s[63:0];
        end
        return s[128] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endfunction

    always_comb begin
        w_limit = (i_max_iterations > STEP_W'(ITER_CAP)) ? STEP_W'(ITER_CAP)
                                                         : i_max_iterations;
        w_mag   = r_acc_rr + r_acc_ii;
        w_esc   = (r_k != '0) && (w_mag > THR);
        case (r_cnt[3:2])
            2'd0: begin
                w_a = r_ar;
                w_b = r_ar;
            end
            2'd1: begin
                w_a = r_ai;
                w_b = r_ai;
            end
            default: begin
                w_a = r_ar;
                w_b = r_ai;
            end
        endcase
        w_ah = r_cnt[1] ? w_a[63:32] : w_a[31:0];
        w_bh = r_cnt[0] ? w_b[63:32] : w_b[31:0];
        case (r_pp_sh)
            2'd0:    w_ppx = {64'd0, r_pp};
            2'd1:    w_ppx = {32'd0, r_pp, 32'd0};
            default: w_ppx = {r_pp, 64'd0};
        endcase
        w_re_x = ($signed({r_re[127], r_re}) >>> FRAC_BITS)
               + $signed({{65{r_cr[63]}}, r_cr});
        w_im_x = ($signed({r_im[127], r_im}) >>> (FRAC_BITS - 1))
               + $signed({{65{r_ci[63]}}, r_ci});
    end

    assign o_qpop   = (r_state == B_IDLE) && !i_qempty;
    assign o_rvalid = (r_state == B_OUT);
    assign o_res    = '{col: r_col, row: r_row, escaped: r_escaped,
                        estep: r_estep, cidx: r_cidx};

    msep_color #(
        .FRAC_BITS (FRAC_BITS)
    ) u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == B_CHK) && w_esc),
        .i_mag   (w_mag),
        .i_step  (r_k - 1'b1),
        .i_pal   (i_pal),
        .o_done  (w_cdone),
        .o_index (w_cidx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_pp_v  <= 1'b0;
        end else begin
            // partial product stage, accumulated in the following cycle
            r_pp     <= w_ah * w_bh;
            r_pp_sel <= r_cnt[3:2];
            r_pp_sh  <= 2'({1'b0, r_cnt[1]} + {1'b0, r_cnt[0]});
            r_pp_v   <= (r_state == B_MUL) && (r_cnt < PP_LAST);
            if (r_pp_v) begin
                case (r_pp_sel)
                    2'd0:    r_acc_rr <= r_acc_rr + w_ppx;
                    2'd1:    r_acc_ii <= r_acc_ii + w_ppx;
                    default: r_acc_ri <= r_acc_ri + w_ppx;
                endcase
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_qempty) begin
                        r_col    <= i_pix.col;
                        r_row    <= i_pix.row;
                        r_cr     <= i_pix.cr;
                        r_ci     <= i_pix.ci;
                        r_sr     <= 1'b0;
                        r_si     <= 1'b0;
                        r_acc_rr <= '0;
                        r_acc_ii <= '0;
                        r_acc_ri <= '0;
                        r_k      <= '0;
                        r_state  <= B_CHK;
                    end
                end
                B_CHK: begin
                    // squares of the current z double as its magnitude
                    if (w_esc) begin
                        r_estep <= r_k - 1'b1;
                        r_state <= B_COLOR;
                    end else if (r_k == w_limit) begin
                        r_escaped <= 1'b0;
                        r_estep   <= '0;
                        r_cidx    <= '0;
                        r_state   <= B_OUT;
                    end else begin
                        r_state <= B_UPD1;
                    end
                end
                B_UPD1: begin
                    r_re    <= r_acc_rr - r_acc_ii;
                    r_im    <= (r_sr ^ r_si) ? (~r_acc_ri + 128'd1) : r_acc_ri;
                    r_state <= B_UPD2;
                end
                B_UPD2: begin
                    r_zr    <= sat64(w_re_x);
                    r_zi    <= sat64(w_im_x);
                    r_k     <= r_k + 1'b1;
                    r_state <= B_ABS;
                end
                B_ABS: begin
                    r_ar     <= r_zr[63] ? (~r_zr + 64'd1) : r_zr;
                    r_ai     <= r_zi[63] ? (~r_zi + 64'd1) : r_zi;
                    r_sr     <= r_zr[63];
                    r_si     <= r_zi[63];
                    r_acc_rr <= '0;
                    r_acc_ii <= '0;
                    r_acc_ri <= '0;
                    r_cnt    <= '0;
                    r_state  <= B_MUL;
                end
                B_MUL: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == PP_LAST) begin
                        r_state <= B_CHK;
                    end
                end
                B_COLOR: begin
                    if (w_cdone) begin
                        r_escaped <= 1'b1;
                        r_cidx    <= w_cidx;
                        r_state   <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!i_rfull) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/mandelbrot_smooth_escape_pixel.sv
`timescale 1ns / 1ps
// Escape-time pixel engine with smoothed palette index.
// Input queue side: present i_column / i_row_index with push; a word is taken
// on a clock edge with push high and full low. Result queue side: while empty
// is low the oldest result sits on the o_ ports; pop with empty low takes it.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 corner real, 1 corner imag, 2 pixel step, 3 max iterations, 4 palette
// size). Write only while no pixel is in flight; the block does not enforce it.
// The front forms the real and then the imaginary part of c; a two-word queue feeds the back end.
// The back end runs each z update on one shared 32x32 multiplier: 12 partial
// products, then the escape test and the update of z. An escaped pixel then
// goes through the log2 / square root / modulo unit. The back end finishes one
// pixel before it takes the next; the front takes the next pixel while the
// back end works. A two-word result queue holds finished results; if the
// receiver stalls with it full, the back end waits at its output and the input
// side fills up and raises full.
// Reset clears all queues and loads the register defaults (iterations 200,
// palette 256, corner and step 0).
module mandelbrot_smooth_escape_pixel
    import msep_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ITER_CAP  = ITER_CAP_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [COORD_W-1:0]   i_column,
    input  logic [COORD_W-1:0]   i_row_index,
    output logic                 empty,
    input  logic                 pop,
    output logic [COORD_W-1:0]   o_out_column,
    output logic [COORD_W-1:0]   o_out_row,
    output logic                 o_escaped,
    output logic [STEP_W-1:0]    o_escape_step,
    output logic [CIDX_W-1:0]    o_color_index,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);
    logic [63:0]       r_corner_real;
    logic [63:0]       r_corner_imag;
    logic [62:0]       r_pixel_step;
    logic [STEP_W-1:0] r_max_iter;
    logic [PAL_W-1:0]  r_pal;
    logic [PAL_W-1:0]  w_pal;

    logic f_valid;
    t_pix f_pix;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_pix q_pix;
    logic b_valid;
    t_res b_res;
    logic res_full;
    t_res res_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_real <= '0;
            r_corner_imag <= '0;
            r_pixel_step  <= '0;
            r_max_iter    <= STEP_W'(200);
            r_pal         <= PAL_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CORNER_REAL: r_corner_real <= i_cfg_data;
                CFG_CORNER_IMAG: r_corner_imag <= i_cfg_data;
                CFG_PIXEL_STEP:  r_pixel_step  <= i_cfg_data[62:0];
                CFG_MAX_ITER:    r_max_iter    <= i_cfg_data[STEP_W-1:0];
                CFG_PALETTE:     r_pal         <= i_cfg_data[PAL_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above the table size as the table size
    assign w_pal = (r_pal == '0) ? PAL_W'(1)
                 : ((r_pal > PAL_W'(PAL_MAX)) ? PAL_W'(PAL_MAX) : r_pal);

    msep_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_column      (i_column),
        .i_row_index   (i_row_index),
        .i_corner_real (r_corner_real),
        .i_corner_imag (r_corner_imag),
        .i_pixel_step  (r_pixel_step),
        .o_valid       (f_valid),
        .o_pix         (f_pix),
        .i_qfull       (q_full)
    );

    msep_fifo #(
        .W     ($bits(t_pix)),
        .DEPTH (2)
    ) u_pix_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid && !q_full),
        .i_data  (f_pix),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_pix)
    );

    msep_iter #(
        .FRAC_BITS (FRAC_BITS),
        .ITER_CAP  (ITER_CAP)
    ) u_iter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_qempty         (q_empty),
        .o_qpop           (q_pop),
        .i_pix            (q_pix),
        .i_max_iterations (r_max_iter),
        .i_pal            (w_pal),
        .o_rvalid         (b_valid),
        .o_res            (b_res),
        .i_rfull          (res_full)
    );

    msep_fifo #(
        .W     ($bits(t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_valid && !res_full),
        .i_data  (b_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_word)
    );

    assign o_out_column  = res_word.col;
    assign o_out_row     = res_word.row;
    assign o_escaped     = res_word.escaped;
    assign o_escape_step = res_word.estep;
    assign o_color_index = res_word.cidx;

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("front not busy after taking a word");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_no_escape_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_escaped) |-> (o_escape_step == '0 && o_color_index == '0))
        else $error("bounded pixel carries step or color");

    a_res_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_valid && res_full) |=> b_valid)
        else $error("result lost while result queue full");

endmodule
